[rtl/pcx_rle_line_encoder_top_assert.svh]
// ---------------------------------------------------------------------------
// PCX RLE line encoder assertion macros
// Shared concurrent assertion wrappers for the encoder checkers.
// ---------------------------------------------------------------------------
`ifndef PCX_RLE_LINE_ENCODER_TOP_ASSERT_SVH
`define PCX_RLE_LINE_ENCODER_TOP_ASSERT_SVH

// checked only while out of reset
`define PLR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define PLR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[rtl/plr_pkg.sv]
// ---------------------------------------------------------------------------
// plr_pkg
// Types, constants and helpers shared by the PCX RLE line encoder.
// ---------------------------------------------------------------------------
package plr_pkg;

  localparam int unsigned WidthW   = 15;
  localparam int unsigned PixW     = 8;
  localparam int unsigned CntW     = 6;
  localparam int unsigned QDepth   = 4;
  localparam int unsigned QPtrW    = $clog2(QDepth);
  localparam int unsigned QCntW    = $clog2(QDepth + 1);
  localparam int unsigned SlotN    = 5;

  localparam logic [WidthW-1:0] WidthReset = 15'd320;
  localparam logic [PixW-1:0]   RunFlag    = 8'hC0;
  localparam logic [CntW-1:0]   RunMax     = 6'd63;

  // byte slots of one command, lowest goes out first
  localparam logic [SlotN-1:0] SlotACode = 5'b00001;
  localparam logic [SlotN-1:0] SlotAVal  = 5'b00010;
  localparam logic [SlotN-1:0] SlotBCode = 5'b00100;
  localparam logic [SlotN-1:0] SlotBVal  = 5'b01000;
  localparam logic [SlotN-1:0] SlotPad   = 5'b10000;

  // a: run flushed by a new value or a full run, b: run flushed at end of line
  typedef struct packed {
    logic            a_vld;
    logic [PixW-1:0] a_val;
    logic [CntW-1:0] a_cnt;
    logic            eol;
    logic [PixW-1:0] b_val;
    logic [CntW-1:0] b_cnt;
    logic            pad;
  } cmd_t;

  function automatic logic is_literal(logic [PixW-1:0] val, logic [CntW-1:0] cnt);
    return (cnt == CntW'(1)) && (val < RunFlag);
  endfunction

  function automatic logic [SlotN-1:0] cmd_slots(cmd_t c);
    logic [SlotN-1:0] m;
    m = '0;
    if (c.a_vld) begin
      m = m | SlotAVal;
      if (!is_literal(c.a_val, c.a_cnt)) begin
        m = m | SlotACode;
      end
    end
    if (c.eol) begin
      m = m | SlotBVal;
      if (!is_literal(c.b_val, c.b_cnt)) begin
        m = m | SlotBCode;
      end
      if (c.pad) begin
        m = m | SlotPad;
      end
    end
    return m;
  endfunction

endpackage

[rtl/pcx_rle_line_encoder_top.sv]
// ---------------------------------------------------------------------------
// pcx_rle_line_encoder_top
// PCX run-length encoder for 8-bit pixels, one image line at a time.
// ---------------------------------------------------------------------------
// Pixels are taken one per cycle while the four-entry command queue has room;
// each pixel yields zero to five code bytes, and the output side sends one
// byte per cycle unless stalled, so a sustained rate of one pixel per cycle
// holds as long as the average output stays at or below one byte per pixel.
// Long stretches of literals or single high pixels fill the queue and
// s_axis_tready drops until the byte sequencer catches up. Bytes pass the
// queue, command and output registers. line_width (cfg_wdata_i) applies
// from the next pixel on; zero acts as one. m_axis_tlast marks the final
// byte of an image line, m_axis_tuser the final byte caused by one pixel.
module pcx_rle_line_encoder_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [plr_pkg::WidthW-1:0]   cfg_wdata_i,   // line_width
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,  // [7:0] pixel
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [7:0]                   m_axis_tdata,  // [7:0] code_byte
  output logic                         m_axis_tlast,  // line_end
  output logic [0:0]                   m_axis_tuser   // [0] last_of_batch
);
  import plr_pkg::*;

  logic push, full, pop, nempty;
  cmd_t push_cmd, pop_cmd;

  plr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pix_valid_i (s_axis_tvalid),
    .pix_ready_o (s_axis_tready),
    .pix_i       (s_axis_tdata),
    .cmd_push_o  (push),
    .cmd_o       (push_cmd),
    .cmd_full_i  (full)
  );

  plr_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .wdata_i  (push_cmd),
    .full_o   (full),
    .pop_i    (pop),
    .nempty_o (nempty),
    .rdata_o  (pop_cmd)
  );

  plr_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_nempty_i   (nempty),
    .cmd_i          (pop_cmd),
    .cmd_pop_o      (pop),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_byte_o     (m_axis_tdata),
    .out_line_end_o (m_axis_tlast),
    .out_last_o     (m_axis_tuser[0])
  );

endmodule

[rtl/plr_front.sv]
// ---------------------------------------------------------------------------
// plr_front
// Run tracking, line column count; a flush command per run or line end.
// ---------------------------------------------------------------------------
module plr_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [plr_pkg::WidthW-1:0]    cfg_wdata_i,
  input  logic                          pix_valid_i,
  output logic                          pix_ready_o,
  input  logic [plr_pkg::PixW-1:0]      pix_i,
  output logic                          cmd_push_o,
  output plr_pkg::cmd_t                 cmd_o,
  input  logic                          cmd_full_i
);
  import plr_pkg::*;

  logic [WidthW-1:0] width_q, width_d;
  logic [PixW-1:0]   run_val_q, run_val_d;
  logic [CntW-1:0]   run_cnt_q, run_cnt_d;
  logic [WidthW-1:0] col_q, col_d;

  logic              take;
  logic              match;
  logic [WidthW:0]   col_inc;
  logic [WidthW:0]   eff_width;
  logic              eol;
  logic [PixW-1:0]   new_val;
  logic [CntW-1:0]   new_cnt;

  assign pix_ready_o = !cmd_full_i;
  assign take        = pix_valid_i && pix_ready_o;

  assign match     = (run_cnt_q != '0) && (pix_i == run_val_q) && (run_cnt_q < RunMax);
  assign new_val   = match ? run_val_q : pix_i;
  assign new_cnt   = match ? run_cnt_q + CntW'(1) : CntW'(1);
  assign col_inc   = {1'b0, col_q} + (WidthW+1)'(1);
  // zero width behaves as one
  assign eff_width = (width_q == '0) ? (WidthW+1)'(1) : {1'b0, width_q};
  assign eol       = col_inc >= eff_width;

  always_comb begin
    cmd_o.a_vld = !match && (run_cnt_q != '0);
    cmd_o.a_val = run_val_q;
    cmd_o.a_cnt = run_cnt_q;
    cmd_o.eol   = eol;
    cmd_o.b_val = new_val;
    cmd_o.b_cnt = new_cnt;
    cmd_o.pad   = eff_width[0];
  end

  assign cmd_push_o = take && (cmd_o.a_vld || eol);

  always_comb begin
    width_d   = cfg_we_i ? cfg_wdata_i : width_q;
    run_val_d = run_val_q;
    run_cnt_d = run_cnt_q;
    col_d     = col_q;
    if (take) begin
      run_val_d = new_val;
      run_cnt_d = eol ? '0 : new_cnt;
      col_d     = eol ? '0 : col_inc[WidthW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= WidthReset;
      run_val_q <= '0;
      run_cnt_q <= '0;
      col_q     <= '0;
    end else begin
      width_q   <= width_d;
      run_val_q <= run_val_d;
      run_cnt_q <= run_cnt_d;
      col_q     <= col_d;
    end
  end

endmodule

[rtl/plr_fifo.sv]
// ---------------------------------------------------------------------------
// plr_fifo
// Small command queue between the run tracker and the byte sequencer.
// ---------------------------------------------------------------------------
module plr_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  plr_pkg::cmd_t wdata_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          nempty_o,
  output plr_pkg::cmd_t rdata_o
);
  import plr_pkg::*;

  cmd_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o   = cnt_q == QCntW'(QDepth);
  assign nempty_o = cnt_q != '0;
  assign rdata_o  = mem_q[rd_ptr_q];
  assign do_push  = push_i && !full_o;
  assign do_pop   = pop_i && nempty_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + QPtrW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + QPtrW'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

[rtl/plr_back.sv]
// ---------------------------------------------------------------------------
// plr_back
// Byte sequencer: expands commands to bytes, one per cycle unless stalled.
// ---------------------------------------------------------------------------
module plr_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cmd_nempty_i,
  input  plr_pkg::cmd_t             cmd_i,
  output logic                      cmd_pop_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [plr_pkg::PixW-1:0]  out_byte_o,
  output logic                      out_line_end_o,
  output logic                      out_last_o
);
  import plr_pkg::*;

  cmd_t             cur_q, cur_d;
  logic [SlotN-1:0] slots_q, slots_d;
  logic             ov_q, ov_d;
  logic [PixW-1:0]  byte_q, byte_d;
  logic             lend_q, lend_d;
  logic             last_q, last_d;

  logic             emit;
  logic [SlotN-1:0] low, rest;
  logic             load;
  logic [PixW-1:0]  sel_byte;
  logic             sel_lend;

  assign emit = (slots_q != '0) && (!ov_q || out_ready_i);
  assign low  = slots_q & (~slots_q + SlotN'(1));
  assign rest = slots_q & ~low;
  // fetch a command when idle or as the last byte of this one goes out
  assign load = cmd_nempty_i && ((slots_q == '0) || (emit && (rest == '0)));
  assign cmd_pop_o = load;

  always_comb begin
    sel_byte = '0;
    sel_lend = 1'b0;
    case (low)
      SlotACode: sel_byte = RunFlag | {2'b00, cur_q.a_cnt};
      SlotAVal:  sel_byte = cur_q.a_val;
      SlotBCode: sel_byte = RunFlag | {2'b00, cur_q.b_cnt};
      SlotBVal: begin
        sel_byte = cur_q.b_val;
        sel_lend = !cur_q.pad;
      end
      SlotPad: begin
        sel_byte = '0;
        sel_lend = 1'b1;
      end
      default: begin
        sel_byte = '0;
        sel_lend = 1'b0;
      end
    endcase
  end

  always_comb begin
    cur_d   = load ? cmd_i : cur_q;
    slots_d = load ? cmd_slots(cmd_i) : (emit ? rest : slots_q);
    ov_d    = ov_q;
    byte_d  = byte_q;
    lend_d  = lend_q;
    last_d  = last_q;
    if (emit) begin
      ov_d   = 1'b1;
      byte_d = sel_byte;
      lend_d = sel_lend;
      last_d = rest == '0;
    end else if (out_ready_i) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    byte_q <= byte_d;
    lend_q <= lend_d;
    last_q <= last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_q <= '0;
      ov_q    <= 1'b0;
    end else begin
      slots_q <= slots_d;
      ov_q    <= ov_d;
    end
  end

  assign out_valid_o    = ov_q;
  assign out_byte_o     = byte_q;
  assign out_line_end_o = lend_q;
  assign out_last_o     = last_q;

endmodule

[rtl/plr_checker.sv]
// ---------------------------------------------------------------------------
// plr_checker
// Port-level checks on the encoder, bound to the top level.
// ---------------------------------------------------------------------------
`include "pcx_rle_line_encoder_top_assert.svh"

module plr_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [7:0]                  m_axis_tdata,
  input logic                        m_axis_tlast,
  input logic [0:0]                  m_axis_tuser
);

  // a stalled byte stays put
  `PLR_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable({m_axis_tdata, m_axis_tlast, m_axis_tuser}), "output changed while stalled")

  // a line always ends on the final byte of a pixel's burst
  `PLR_ASSERT(a_tlast_last, m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[0], "line end not on last byte of a pixel")

  // nothing pending out of reset
  `PLR_ASSERT_ALWAYS(a_reset_idle, $rose(rst_ni) |-> !m_axis_tvalid, "output valid right after reset")

endmodule

bind pcx_rle_line_encoder_top plr_checker u_plr_checker (.*);

[tb/pcx_rle_line_encoder_top_test.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// pcx_rle_line_encoder_top_test
// Drives pixels into the PCX line encoder and predicts every code byte with
// its line_end and last_of_batch flags. Both stream sides stall at random.
// Line widths change between phases, including 0, 1, 32767 and mid-line.
// ---------------------------------------------------------------------------
module pcx_rle_line_encoder_top_test;
  import plr_pkg::*;

  localparam logic [PixW-1:0] PadByte       = 8'h00;
  localparam int unsigned     IdleSettle    = 8;
  localparam int unsigned     TimeoutCycles = 100000;

  typedef struct packed {
    logic [PixW-1:0] code;
    logic            line_end;
    logic            last_of_batch;
  } code_byte_t;

  // predicts the encoded byte stream and checks the bytes the block sends
  class code_scoreboard;
    logic [WidthW-1:0] line_width;
    logic [PixW-1:0]   run_value;
    logic [CntW-1:0]   run_count;
    logic [WidthW-1:0] column;
    code_byte_t        code_due[$];
    int unsigned       errors;
    int unsigned       pixels_seen;
    int unsigned       bytes_seen;
    int unsigned       line_ends_seen;

    function new();
      line_width     = WidthReset;
      run_value      = '0;
      run_count      = '0;
      column         = '0;
      errors         = 0;
      pixels_seen    = 0;
      bytes_seen     = 0;
      line_ends_seen = 0;
    endfunction

    function void set_width(logic [WidthW-1:0] w);
      line_width = w;
    endfunction

    function int unsigned pending();
      return code_due.size();
    endfunction

    function void emit_byte(logic [PixW-1:0] b, logic eol);
      code_byte_t c;
      c.code          = b;
      c.line_end      = eol;
      c.last_of_batch = 1'b0;
      code_due.push_back(c);
    endfunction

    function void flush_run(logic eol);
      if (run_count == '0) begin
        return;
      end
      if (run_count == CntW'(1) && run_value < RunFlag) begin
        emit_byte(run_value, eol);
      end else begin
        emit_byte(RunFlag | {2'b00, run_count}, 1'b0);
        emit_byte(run_value, eol);
      end
      run_count = '0;
    endfunction

    function void note_pixel(logic [PixW-1:0] px);
      logic [WidthW:0] eff;
      logic            pad;
      int unsigned     queued;
      queued = code_due.size();
      eff    = (line_width == '0) ? (WidthW+1)'(1) : {1'b0, line_width};
      pad    = eff[0];
      pixels_seen++;
      if (run_count != '0 && px == run_value && run_count < RunMax) begin
        run_count = run_count + CntW'(1);
      end else begin
        flush_run(1'b0);
        run_value = px;
        run_count = CntW'(1);
      end
      // column may already sit past a width that shrank mid-line
      if ({1'b0, column} + (WidthW+1)'(1) >= eff) begin
        flush_run(!pad);
        if (pad) begin
          emit_byte(PadByte, 1'b1);
        end
        column = '0;
      end else begin
        column = column + WidthW'(1);
      end
      if (code_due.size() > queued) begin
        code_due[code_due.size()-1].last_of_batch = 1'b1;
      end
    endfunction

    function void check_code(logic [PixW-1:0] b, logic eol, logic last);
      code_byte_t want;
      bytes_seen++;
      if (eol) begin
        line_ends_seen++;
      end
      if (code_due.size() == 0) begin
        $error("code byte %02h arrived with nothing outstanding", b);
        errors++;
        return;
      end
      want = code_due.pop_front();
      if (b !== want.code) begin
        $error("code_byte: expected %02h, got %02h", want.code, b);
        errors++;
      end
      if (eol !== want.line_end) begin
        $error("line_end: expected %0b, got %0b", want.line_end, eol);
        errors++;
      end
      if (last !== want.last_of_batch) begin
        $error("last_of_batch: expected %0b, got %0b", want.last_of_batch, last);
        errors++;
      end
    endfunction
  endclass

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              cfg_we_i      = 1'b0;
  logic [WidthW-1:0] cfg_wdata_i   = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [7:0]        s_axis_tdata  = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [7:0]        m_axis_tdata;
  logic              m_axis_tlast;
  logic [0:0]        m_axis_tuser;

  code_scoreboard board = new();
  bit             steady = 1'b0;     // both sides run without idling
  int unsigned    widths_used = 0;

  pcx_rle_line_encoder_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #1 clk_i = ~clk_i;

  // output side: check each transfer, stall at random
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      board.check_code(m_axis_tdata, m_axis_tlast, m_axis_tuser[0]);
    end
    m_axis_tready <= steady || ($urandom_range(99) >= 11);
  end

  // valid is left high after a transfer; the next call either reuses it
  // or drops it, so only one assignment lands per time step
  task automatic push_pixel(input logic [7:0] px);
    if (!steady && $urandom_range(99) < 11) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 25);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    board.note_pixel(px);
  endtask

  task automatic push_all(input logic [7:0] pixels[$]);
    foreach (pixels[i]) begin
      push_pixel(pixels[i]);
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    // a pixel that yields no byte may still be in flight
    repeat (IdleSettle) @(posedge clk_i);
  endtask

  task automatic write_width(input logic [WidthW-1:0] w);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    board.set_width(w);
    cfg_we_i <= 1'b0;
    widths_used++;
  endtask

  // mostly runs of equal pixels, some long enough to overflow a run,
  // mixed with scattered random pixels
  task automatic push_runs(input int unsigned count, input int unsigned long_pct,
                           input int unsigned pause_at);
    int unsigned sent;
    int unsigned len;
    int unsigned r;
    logic [7:0]  val;
    bit          scatter;
    sent = 0;
    while (sent < count) begin
      r       = $urandom_range(99);
      scatter = ($urandom_range(9) == 0);
      if (r < long_pct) begin
        len = $urandom_range(70, 60);
      end else if (r < long_pct + 20) begin
        len = $urandom_range(20, 5);
      end else begin
        len = $urandom_range(4, 1);
      end
      val = ($urandom_range(3) == 0) ? 8'($urandom_range(255, 192)) : 8'($urandom);
      repeat (len) begin
        push_pixel(scatter ? 8'($urandom) : val);
        sent++;
        if (sent == pause_at) begin
          wait_drained();
        end
      end
    end
  endtask

  initial begin
    logic [7:0] pixels[$];
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset width: literal and run edges around the flag value
    pixels = '{8'h00, 8'hFF, 8'hBF, 8'hC0, 8'hC0, 8'h7F, 8'h7F, 8'h7F, 8'h01};
    push_all(pixels);
    write_width(15'd1);
    pixels = '{8'hC5, 8'h10};
    push_all(pixels);
    // zero width behaves as one
    write_width(15'd0);
    pixels = '{8'h00, 8'hFF};
    push_all(pixels);
    write_width(15'd4);
    pixels = '{8'h11, 8'h11, 8'h11, 8'h11};
    push_all(pixels);
    write_width(15'd40);
    pixels = '{8'h80, 8'h80, 8'hC1, 8'h55, 8'h55};
    push_all(pixels);
    // shrink below the current column: next pixel closes the line
    write_width(15'd5);
    pixels = '{8'h55};
    push_all(pixels);

    write_width(15'h7FFF);
    push_runs(25, 5, 0);
    write_width(15'd7);
    steady = 1'b1;
    push_runs(30, 5, 0);
    wait_drained();
    steady = 1'b0;
    write_width(15'd64);
    push_runs(70, 40, 0);
    write_width(15'd2);
    push_runs(25, 5, 0);
    write_width(15'd3);
    push_runs(25, 5, 0);
    write_width(15'd130);
    push_runs(40, 40, 20);
    write_width(15'd1);
    push_runs(15, 5, 0);
    write_width(WidthW'($urandom_range(300, 1)));
    push_runs(25, 10, 0);
    wait_drained();

    $display("covered %0d pixels, %0d code bytes and %0d line ends",
             board.pixels_seen, board.bytes_seen, board.line_ends_seen);
    $display("over %0d width settings, among them 0, 1, 32767 and a mid-line shrink",
             widths_used);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #(TimeoutCycles * 2);
    $display("timeout with %0d code bytes outstanding", board.pending());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/plr_pkg.sv
rtl/plr_front.sv
rtl/plr_fifo.sv
rtl/plr_back.sv
rtl/pcx_rle_line_encoder_top.sv
rtl/plr_checker.sv
tb/pcx_rle_line_encoder_top_test.sv
